// File: src/polyline_arc_length_sampler_core_defines.svh
// ----------------------------------------------------------------------------
// polyline arc-length sampler assertion macros
// shared assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef POLYLINE_ARC_LENGTH_SAMPLER_CORE_DEFINES_SVH
`define POLYLINE_ARC_LENGTH_SAMPLER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property holds at every clock out of reset
`define PALS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// consequent holds in the cycle after antecedent
`define PALS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PALS_ASSERT(lbl, prop, msg)
`define PALS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/pals_pkg.sv
// ----------------------------------------------------------------------------
// pals_pkg
// constants, codes and the cordic angle table of the arc-length sampler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pals_pkg;
	localparam int MAX_POINTS = 64;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam int CORDIC_STEPS = 17;
	localparam logic signed [24:0] HALF_TURN_FINE = 25'sd2949120;
	localparam logic signed [16:0] HEAD_MAX = 17'sd11520;

	typedef logic signed [23:0] coord_t;
	typedef logic signed [24:0] delta_t;

	// arctangent of 2^-i in 1/16384 degree
	function automatic logic [19:0] atan_fine(input logic [4:0] i);
		logic [19:0] r;
		case (i)
			5'd0: r = 20'd737280;
			5'd1: r = 20'd435242;
			5'd2: r = 20'd229970;
			5'd3: r = 20'd116736;
			5'd4: r = 20'd58595;
			5'd5: r = 20'd29326;
			5'd6: r = 20'd14667;
			5'd7: r = 20'd7334;
			5'd8: r = 20'd3667;
			5'd9: r = 20'd1833;
			5'd10: r = 20'd917;
			5'd11: r = 20'd458;
			5'd12: r = 20'd229;
			5'd13: r = 20'd115;
			5'd14: r = 20'd57;
			5'd15: r = 20'd29;
			5'd16: r = 20'd14;
			default: r = 20'd0;
		endcase
		return r;
	endfunction
endpackage

// File: src/pals_isqrt.sv
// ----------------------------------------------------------------------------
// pals_isqrt
// floor square root of a 49-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pals_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [48:0] radicand,
	output logic        done,
	output logic [24:0] root
);
	logic [48:0] v_q;
	logic [49:0] res_q;
	logic [4:0]  k_q;
	logic        busy_q;
	logic        done_q;
	logic [49:0] bitv;
	logic [49:0] trial;
	logic        take;

	// trial subtraction for the current digit
	always_comb begin
		bitv  = 50'd1 << {k_q, 1'b0};
		trial = res_q + bitv;
		take  = {1'b0, v_q} >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && k_q == 5'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// digit iteration
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			k_q   <= 5'd24;
		end else if (busy_q) begin
			if (take) begin
				v_q   <= v_q - trial[48:0];
				res_q <= (res_q >> 1) + bitv;
			end else begin
				res_q <= res_q >> 1;
			end
			k_q <= k_q - 5'd1;
		end
	end

	assign done = done_q;
	assign root = res_q[24:0];
endmodule

// File: src/pals_div.sv
// ----------------------------------------------------------------------------
// pals_div
// restoring divider, 57-bit magnitude by 32-bit length, 25-bit quotient
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pals_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [56:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [24:0] quotient
);
	logic [32:0] rem_q;
	logic [24:0] low_q;
	logic [24:0] quo_q;
	logic [31:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] shifted;
	logic [33:0] diff;

	// quotient stays below 2^25, so the upper bits start below the divisor
	always_comb begin
		shifted = {rem_q, low_q[24]};
		diff    = shifted - {2'b00, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 5'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend[56:25]};
			low_q <= dividend[24:0];
			dvs_q <= divisor;
			quo_q <= '0;
			cnt_q <= 5'd24;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[23:0], 1'b1};
			end else begin
				rem_q <= shifted[32:0];
				quo_q <= {quo_q[23:0], 1'b0};
			end
			low_q <= {low_q[23:0], 1'b0};
			cnt_q <= cnt_q - 5'd1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: src/pals_cordic.sv
// ----------------------------------------------------------------------------
// pals_cordic
// vectoring cordic heading, one rotation per cycle, 1/64 degree result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pals_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  pals_pkg::delta_t      dx,
	input  pals_pkg::delta_t      dy,
	output logic                  done,
	output logic signed [14:0]    heading
);
	logic signed [47:0] x_q;
	logic signed [47:0] y_q;
	logic signed [24:0] z_q;
	logic [4:0]         i_q;
	logic               busy_q;
	logic               done_q;
	logic               zero_q;
	logic signed [47:0] xs;
	logic signed [47:0] ys;
	logic signed [24:0] ang;
	logic signed [24:0] zr;
	logic signed [24:0] zabs;
	logic signed [24:0] hq;
	logic signed [24:0] dxn;
	logic signed [24:0] dyn;

	always_comb begin
		xs   = x_q >>> i_q;
		ys   = y_q >>> i_q;
		ang  = $signed({5'd0, pals_pkg::atan_fine(i_q)});
		dxn  = -dx;
		dyn  = -dy;
		// round half away from zero, then clamp
		zabs = z_q[24] ? -z_q : z_q;
		zr   = (zabs + 25'sd128) >>> 8;
		hq   = z_q[24] ? -zr : zr;
		if (zero_q)
			hq = '0;
		else if (hq > 25'(pals_pkg::HEAD_MAX))
			hq = 25'(pals_pkg::HEAD_MAX);
		else if (hq < -25'(pals_pkg::HEAD_MAX))
			hq = -25'(pals_pkg::HEAD_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && i_q == 5'(pals_pkg::CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// rotation steps
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (dx == '0) && (dy == '0);
			i_q    <= '0;
			if (dx[24]) begin
				x_q <= {{3{dxn[24]}}, dxn, 20'd0};
				y_q <= {{3{dyn[24]}}, dyn, 20'd0};
				z_q <= dy[24] ? -pals_pkg::HALF_TURN_FINE : pals_pkg::HALF_TURN_FINE;
			end else begin
				x_q <= {{3{dx[24]}}, dx, 20'd0};
				y_q <= {{3{dy[24]}}, dy, 20'd0};
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (!y_q[47]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end
			i_q <= i_q + 5'd1;
		end
	end

	assign done    = done_q;
	assign heading = hq[14:0];
endmodule

// File: src/polyline_arc_length_sampler_core.sv
// ----------------------------------------------------------------------------
// polyline_arc_length_sampler_core
// polyline store with arc-length append and distance query
// ----------------------------------------------------------------------------
// channel | signals                                      | dir
// in      | in_valid in_ready op vertex_x vertex_y travel| in
// out     | out_valid out_ready pos_x pos_y heading      | out
//         | path_length vertex_count status              |
//
// clear, first or full append, empty query, unused op: go from idle straight to the finish state
// append: squares dx and dy in turn, then runs the 25-step square root unit
// query: the cumulative length scan, the cordic unit and two divider runs;
//   the scan runs only for travel short of the total, the dividers only to interpolate
// in_ready is high only in the idle state; one item is at work at a time
// a finished beat waits in the output register until out_ready
// reset clears count and total; the vertex stores are left undefined
`timescale 1ns / 1ps
`include "polyline_arc_length_sampler_core_defines.svh"
module polyline_arc_length_sampler_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [23:0] vertex_x,
	input  logic signed [23:0] vertex_y,
	input  logic signed [31:0] travel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] pos_x,
	output logic signed [23:0] pos_y,
	output logic signed [14:0] heading,
	output logic [31:0]        path_length,
	output logic [6:0]         vertex_count,
	output logic [1:0]         status
);
	localparam int AW = pals_pkg::AW;
	localparam int CW = pals_pkg::CW;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_SQX     = 5'd1;
	localparam logic [4:0] S_SQY     = 5'd2;
	localparam logic [4:0] S_SQRT_GO = 5'd3;
	localparam logic [4:0] S_SQRT    = 5'd4;
	localparam logic [4:0] S_QSTART  = 5'd5;
	localparam logic [4:0] S_SCAN    = 5'd6;
	localparam logic [4:0] S_RD0     = 5'd7;
	localparam logic [4:0] S_RD1     = 5'd8;
	localparam logic [4:0] S_RD2     = 5'd9;
	localparam logic [4:0] S_RD3     = 5'd10;
	localparam logic [4:0] S_HEAD_GO = 5'd11;
	localparam logic [4:0] S_HEAD    = 5'd12;
	localparam logic [4:0] S_INTERP  = 5'd13;
	localparam logic [4:0] S_MUL     = 5'd14;
	localparam logic [4:0] S_DIV_GO  = 5'd15;
	localparam logic [4:0] S_DIV     = 5'd16;
	localparam logic [4:0] S_FIN     = 5'd17;

	logic [4:0] state_q;

	// stores
	pals_pkg::coord_t x_mem [pals_pkg::MAX_POINTS];
	pals_pkg::coord_t y_mem [pals_pkg::MAX_POINTS];
	logic [31:0]      cum_mem [pals_pkg::MAX_POINTS];
	pals_pkg::coord_t x_rd_q;
	pals_pkg::coord_t y_rd_q;
	logic [31:0]      cum_rd_q;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	pals_pkg::coord_t mem_wx;
	pals_pkg::coord_t mem_wy;
	logic [31:0]      mem_wcum;
	logic [AW-1:0]    xy_raddr;
	logic [AW-1:0]    cum_raddr;

	// item and path state
	logic [1:0]         op_q;
	pals_pkg::coord_t   vx_q;
	pals_pkg::coord_t   vy_q;
	logic signed [31:0] d_q;
	logic [CW-1:0]      count_q;
	logic [31:0]        total_q;
	pals_pkg::coord_t   last_x_q;
	pals_pkg::coord_t   last_y_q;
	logic [48:0]        sq_q;
	logic [AW-1:0]      scan_q;
	logic [AW-1:0]      idx_s1;
	logic               valid_s1;
	logic [31:0]        prev_q;
	logic [31:0]        start_q;
	logic [31:0]        len_q;
	logic [AW-1:0]      seg_q;
	pals_pkg::coord_t   ax_q;
	pals_pkg::coord_t   ay_q;
	pals_pkg::coord_t   bx_q;
	pals_pkg::coord_t   by_q;
	pals_pkg::coord_t   pvx_q;
	pals_pkg::coord_t   pvy_q;
	pals_pkg::coord_t   px_q;
	pals_pkg::coord_t   py_q;
	logic signed [14:0] hd_q;
	logic [1:0]         status_q;
	logic               axis_q;
	logic signed [57:0] prod_q;
	logic               out_valid_q;

	// unit handshakes
	logic               sqrt_start;
	logic               sqrt_done;
	logic [24:0]        sqrt_root;
	logic               cordic_start;
	logic               cordic_done;
	logic signed [14:0] cordic_head;
	logic               div_start;
	logic               div_done;
	logic [24:0]        div_quo;

	// datapath helpers
	logic [CW-1:0]      count_m1;
	logic [AW-1:0]      last_idx;
	logic               d_lt_total;
	logic               d_le_zero;
	logic               d_le_cum;
	logic [AW-1:0]      pos_idx;
	pals_pkg::delta_t   seg_dx;
	pals_pkg::delta_t   seg_dy;
	pals_pkg::delta_t   app_dx;
	pals_pkg::delta_t   app_dy;
	logic signed [49:0] app_sq;
	logic [32:0]        total_sum;
	logic [31:0]        total_sat;
	logic [31:0]        num;
	logic signed [57:0] prod;
	logic [56:0]        prod_mag;
	logic signed [25:0] q_signed;
	logic signed [25:0] interp_sum;
	logic               accept;
	logic               interp;

	always_comb begin
		accept     = in_valid && in_ready;
		count_m1   = count_q - CW'(1);
		last_idx   = count_m1[AW-1:0];
		d_lt_total = $signed({d_q[31], d_q}) < $signed({1'b0, total_q});
		d_le_zero  = d_q <= 32'sd0;
		d_le_cum   = $signed({d_q[31], d_q}) <= $signed({1'b0, cum_rd_q});
		if (d_le_zero)
			pos_idx = '0;
		else if (!d_lt_total)
			pos_idx = last_idx;
		else
			pos_idx = seg_q - AW'(1);
		seg_dx     = {bx_q[23], bx_q} - {ax_q[23], ax_q};
		seg_dy     = {by_q[23], by_q} - {ay_q[23], ay_q};
		app_dx     = {vx_q[23], vx_q} - {last_x_q[23], last_x_q};
		app_dy     = {vy_q[23], vy_q} - {last_y_q[23], last_y_q};
		app_sq     = (state_q == S_SQX) ? app_dx * app_dx : app_dy * app_dy;
		total_sum  = {1'b0, total_q} + {8'd0, sqrt_root};
		total_sat  = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
		num        = d_q[31:0] - start_q;
		prod       = (axis_q ? seg_dy : seg_dx) * $signed({1'b0, num});
		prod_mag   = prod_q[57] ? 57'(-prod_q) : prod_q[56:0];
		q_signed   = prod_q[57] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		interp_sum = (axis_q ? {{2{pvy_q[23]}}, pvy_q} : {{2{pvx_q[23]}}, pvx_q}) + q_signed;
		interp     = !d_le_zero && d_lt_total && (len_q != 32'd0);
	end

	// store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wx    = vx_q;
		mem_wy    = vy_q;
		mem_wcum  = total_sat;
		if (state_q == S_IDLE && accept && op == pals_pkg::OP_APPEND &&
		    count_q == CW'(0)) begin
			mem_we    = 1'b1;
			mem_waddr = '0;
			mem_wx    = vertex_x;
			mem_wy    = vertex_y;
			mem_wcum  = '0;
		end else if (state_q == S_SQRT && sqrt_done) begin
			mem_we = 1'b1;
		end
		cum_raddr = scan_q;
		case (state_q)
			S_RD0: xy_raddr = seg_q - AW'(1);
			S_RD1: xy_raddr = seg_q;
			default: xy_raddr = pos_idx;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			x_mem[mem_waddr]   <= mem_wx;
			y_mem[mem_waddr]   <= mem_wy;
			cum_mem[mem_waddr] <= mem_wcum;
		end
		x_rd_q   <= x_mem[xy_raddr];
		y_rd_q   <= y_mem[xy_raddr];
		cum_rd_q <= cum_mem[cum_raddr];
	end

	assign sqrt_start   = (state_q == S_SQRT_GO);
	assign cordic_start = (state_q == S_HEAD_GO) && (count_q >= CW'(2));
	assign div_start    = (state_q == S_DIV_GO);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (op)
							pals_pkg::OP_CLEAR: begin
								count_q <= '0;
								total_q <= '0;
								state_q <= S_FIN;
							end
							pals_pkg::OP_APPEND: begin
								if (count_q >= CW'(pals_pkg::MAX_POINTS)) begin
									state_q <= S_FIN;
								end else if (count_q == CW'(0)) begin
									count_q <= CW'(1);
									state_q <= S_FIN;
								end else begin
									state_q <= S_SQX;
								end
							end
							pals_pkg::OP_QUERY: begin
								state_q <= (count_q == CW'(0)) ? S_FIN : S_QSTART;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_SQX:     state_q <= S_SQY;
				S_SQY:     state_q <= S_SQRT_GO;
				S_SQRT_GO: state_q <= S_SQRT;
				S_SQRT: begin
					if (sqrt_done) begin
						total_q <= total_sat;
						count_q <= count_q + CW'(1);
						state_q <= S_FIN;
					end
				end
				S_QSTART: begin
					valid_s1 <= 1'b0;
					if (count_q >= CW'(2) && d_lt_total)
						state_q <= S_SCAN;
					else
						state_q <= S_RD0;
				end
				S_SCAN: begin
					valid_s1 <= 1'b1;
					if (valid_s1 && d_le_cum) begin
						valid_s1 <= 1'b0;
						state_q  <= S_RD0;
					end
				end
				S_RD0:     state_q <= S_RD1;
				S_RD1:     state_q <= S_RD2;
				S_RD2:     state_q <= S_RD3;
				S_RD3:     state_q <= S_HEAD_GO;
				S_HEAD_GO: state_q <= (count_q >= CW'(2)) ? S_HEAD : S_INTERP;
				S_HEAD: begin
					if (cordic_done)
						state_q <= S_INTERP;
				end
				S_INTERP:  state_q <= interp ? S_MUL : S_FIN;
				S_MUL:     state_q <= S_DIV_GO;
				S_DIV_GO:  state_q <= S_DIV;
				S_DIV: begin
					if (div_done)
						state_q <= axis_q ? S_FIN : S_MUL;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q     <= op;
					vx_q     <= vertex_x;
					vy_q     <= vertex_y;
					d_q      <= travel;
					px_q     <= '0;
					py_q     <= '0;
					hd_q     <= '0;
					status_q <= pals_pkg::ST_OK;
					if (op == pals_pkg::OP_APPEND &&
					    count_q >= CW'(pals_pkg::MAX_POINTS))
						status_q <= pals_pkg::ST_FULL;
					if (op == pals_pkg::OP_QUERY && count_q == CW'(0))
						status_q <= pals_pkg::ST_EMPTY;
					if (op == pals_pkg::OP_APPEND && count_q == CW'(0)) begin
						last_x_q <= vertex_x;
						last_y_q <= vertex_y;
					end
				end
			end
			S_SQX: sq_q <= app_sq[48:0];
			S_SQY: sq_q <= sq_q + app_sq[48:0];
			S_SQRT: begin
				if (sqrt_done) begin
					last_x_q <= vx_q;
					last_y_q <= vy_q;
				end
			end
			S_QSTART: begin
				scan_q  <= AW'(1);
				prev_q  <= '0;
				seg_q   <= last_idx;
				start_q <= '0;
				len_q   <= '0;
			end
			S_SCAN: begin
				idx_s1 <= scan_q;
				if (scan_q != last_idx)
					scan_q <= scan_q + AW'(1);
				if (valid_s1) begin
					if (d_le_cum) begin
						seg_q   <= idx_s1;
						start_q <= prev_q;
						len_q   <= cum_rd_q - prev_q;
					end else begin
						prev_q <= cum_rd_q;
					end
				end
			end
			S_RD1: begin
				ax_q <= x_rd_q;
				ay_q <= y_rd_q;
			end
			S_RD2: begin
				bx_q <= x_rd_q;
				by_q <= y_rd_q;
			end
			S_RD3: begin
				pvx_q <= x_rd_q;
				pvy_q <= y_rd_q;
			end
			S_HEAD: begin
				if (cordic_done)
					hd_q <= cordic_head;
			end
			S_INTERP: begin
				axis_q <= 1'b0;
				if (!interp) begin
					px_q <= pvx_q;
					py_q <= pvy_q;
				end
			end
			S_MUL: prod_q <= prod;
			S_DIV: begin
				if (div_done) begin
					if (axis_q)
						py_q <= interp_sum[23:0];
					else
						px_q <= interp_sum[23:0];
					axis_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
			pos_x        <= (op_q == pals_pkg::OP_QUERY) ? px_q : '0;
			pos_y        <= (op_q == pals_pkg::OP_QUERY) ? py_q : '0;
			heading      <= (op_q == pals_pkg::OP_QUERY) ? hd_q : '0;
			path_length  <= total_q;
			vertex_count <= 7'(count_q);
			status       <= status_q;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	pals_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sq_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	pals_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.dx      (seg_dx),
		.dy      (seg_dy),
		.done    (cordic_done),
		.heading (cordic_head)
	);

	pals_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_mag),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// checks
	`PALS_ASSERT(a_count_range, count_q <= CW'(pals_pkg::MAX_POINTS), "vertex count past table")
	`PALS_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "accepted beat left idle")
	`PALS_ASSERT(a_cordic_state, !cordic_done || state_q == S_HEAD, "heading done out of state")
	`PALS_ASSERT(a_div_state, !div_done || state_q == S_DIV, "divider done out of state")
endmodule
